@@ design/avc_pkg.sv @@
// shared types, constants and the tanh table of the admittance velocity controller
package avc_pkg;

  localparam int unsigned TanhEntries = 256;
  localparam int unsigned TanhIdxW    = $clog2(TanhEntries);
  localparam int unsigned OrientGain  = 256;
  localparam int unsigned G98Q12      = 40141;

  // numerator, divisor and quotient widths of the damping division
  localparam int unsigned NumW  = 41;
  localparam int unsigned DenW  = 18;
  localparam int unsigned IterN = 17;
  localparam int unsigned QuoW  = IterN + 2;
  localparam int unsigned VtW   = 33;

  typedef enum logic [2:0] {
    REG_MASS_LIN    = 3'd0,
    REG_MASS_ANG    = 3'd1,
    REG_DAMP_LIN    = 3'd2,
    REG_DAMP_ANG    = 3'd3,
    REG_LIN_VEL_MAX = 3'd4,
    REG_LIN_VEL_MIN = 3'd5,
    REG_ANG_VEL_MAX = 3'd6,
    REG_ANG_VEL_MIN = 3'd7
  } avc_reg_e;

  typedef struct packed {
    logic signed [15:0] force_fwd;
    logic signed [15:0] torque_yaw;
    logic signed [15:0] meas_lin_vel;
    logic signed [15:0] meas_ang_vel;
    logic signed [15:0] orient_error;
    logic               assist_mode;
  } avc_in_t;

  typedef struct packed {
    logic signed [15:0] lin_cmd;
    logic signed [15:0] ang_cmd;
    logic signed [15:0] virt_torque;
  } avc_out_t;

  typedef struct packed {
    logic        [15:0] mass_lin;
    logic        [15:0] mass_ang;
    logic        [15:0] damp_lin;
    logic        [15:0] damp_ang;
    logic signed [15:0] lin_vel_max;
    logic signed [15:0] lin_vel_min;
    logic signed [15:0] ang_vel_max;
    logic signed [15:0] ang_vel_min;
  } avc_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } avc_div_stat_t;

  typedef logic [TanhEntries-1:0][15:0] tanh_tab_t;

  // tanh(4*i/entries) in Q1.15: series start at 1/256 of the angle, then eight doublings
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t       tab;
    longint unsigned x;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned t;
    longint unsigned den;
    longint unsigned nm;
    longint unsigned qt;
    longint unsigned rm;
    tab = '0;
    for (int i = 0; i < TanhEntries; i++) begin
      x  = (longint'(i) << 32) / TanhEntries;
      a  = x >> 8;
      a2 = (a * a) >> 30;
      t  = a - ((a2 * a) >> 30) / 3;
      for (int k = 0; k < 8; k++) begin
        den = (64'd1 << 30) + ((t * t) >> 30);
        // rounded quotient by long division, one bit per step
        nm  = (t << 31) + (den >> 1);
        qt  = '0;
        rm  = '0;
        for (int b = 63; b >= 0; b--) begin
          rm = {rm[62:0], nm[b]};
          if (rm >= den) begin
            rm    = rm - den;
            qt[b] = 1'b1;
          end
        end
        t = qt;
      end
      tab[i] = 16'((t + (64'd1 << 14)) >> 15);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TanhTab = build_tanh();

endpackage

@@ design/avc_cfg.sv @@
// configuration register file of the admittance velocity controller
module avc_cfg
  import avc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output avc_cfg_t    cfg_o
);

  avc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (avc_reg_e'(cfg_idx_i))
        REG_MASS_LIN:    cfg_d.mass_lin    = cfg_wdata_i;
        REG_MASS_ANG:    cfg_d.mass_ang    = cfg_wdata_i;
        REG_DAMP_LIN:    cfg_d.damp_lin    = cfg_wdata_i;
        REG_DAMP_ANG:    cfg_d.damp_ang    = cfg_wdata_i;
        REG_LIN_VEL_MAX: cfg_d.lin_vel_max = cfg_wdata_i;
        REG_LIN_VEL_MIN: cfg_d.lin_vel_min = cfg_wdata_i;
        REG_ANG_VEL_MAX: cfg_d.ang_vel_max = cfg_wdata_i;
        REG_ANG_VEL_MIN: cfg_d.ang_vel_min = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mass_lin    <= 16'd768;
      cfg_q.mass_ang    <= 16'd256;
      cfg_q.damp_lin    <= 16'd5760;
      cfg_q.damp_ang    <= 16'd1600;
      cfg_q.lin_vel_max <= 16'sd2048;
      cfg_q.lin_vel_min <= 16'sd0;
      cfg_q.ang_vel_max <= 16'sd4096;
      cfg_q.ang_vel_min <= -16'sd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/avc_vtorque.sv @@
// virtual torque: scaled handle torque or table tanh of the orientation error
module avc_vtorque
  import avc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic signed [15:0]    torque_i,
  input  logic signed [15:0]    err_i,
  input  logic                  assist_i,
  output logic signed [VtW-1:0] vt20_o,
  output logic signed [15:0]    vt_sat_o
);

  localparam int unsigned IdxProdW = 17 + TanhIdxW + 1;

  logic signed [VtW-1:0]  vt20_q, vt20_d;
  logic        [16:0]     err_mag;
  logic [IdxProdW-1:0]    idx_prod;
  logic [IdxProdW-1:0]    idx_sh;
  logic [TanhIdxW-1:0]    idx;
  logic [15:0]            tab_val;
  logic [32:0]            gain_prod;
  logic signed [VtW-1:0]  p_val;
  logic signed [VtW-1:0]  torque98;
  logic [VtW-1:0]         vt_mag;
  logic [VtW-1:0]         vt_rnd;

  always_comb begin
    err_mag   = err_i[15] ? 17'(-$signed({err_i[15], err_i})) : {1'b0, err_i};
    idx_prod  = IdxProdW'(err_mag) * IdxProdW'(TanhEntries);
    idx_sh    = idx_prod >> 14;
    // errors past the table end use the last entry
    if (idx_sh >= IdxProdW'(TanhEntries)) begin
      idx = TanhIdxW'(TanhEntries - 1);
    end else begin
      idx = idx_sh[TanhIdxW-1:0];
    end
    tab_val   = TanhTab[idx];
    gain_prod = 33'(32'(16'(OrientGain)) * 32'(tab_val)) + 33'd4;
    p_val     = $signed({3'b000, gain_prod[32:3]});
    torque98  = torque_i * $signed({1'b0, 16'(G98Q12)});
    if (assist_i) begin
      vt20_d = err_i[15] ? p_val : -p_val;
    end else begin
      vt20_d = torque98;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vt20_q <= vt20_d;
    end
  end

  // Q.20 to Q8.8, round half away from zero, then saturate
  always_comb begin
    vt_mag = vt20_q[VtW-1] ? VtW'(-vt20_q) : VtW'(vt20_q);
    vt_rnd = (vt_mag + VtW'(2048)) >> 12;
    if (vt20_q[VtW-1]) begin
      vt_sat_o = (vt_rnd > VtW'(32768)) ? -16'sd32768 : 16'(-$signed(vt_rnd));
    end else begin
      vt_sat_o = (vt_rnd > VtW'(32767)) ? 16'sd32767 : $signed(vt_rnd[15:0]);
    end
  end

  assign vt20_o = vt20_q;

endmodule

@@ design/avc_div.sv @@
// shared restoring divider: rounded signed quotient by 4*damping, saturated past 17 bits
module avc_div
  import avc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic        [15:0]     den_i,
  output avc_div_stat_t          stat_o,
  output logic signed [QuoW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(IterN);

  typedef enum logic [3:0] {
    DV_IDLE  = 4'b0001,
    DV_ROUND = 4'b0010,
    DV_CHECK = 4'b0100,
    DV_ITER  = 4'b1000
  } dv_state_e;

  dv_state_e         dv_state_q, dv_state_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q;
  logic [NumW-1:0]   mag_q;
  logic [15:0]       dd_q;
  logic [DenW-1:0]   rem_q;
  logic [IterN-1:0]  low_q;
  logic [IterN:0]    quo_q;
  logic [DenW-1:0]   dv;
  logic [DenW:0]     rs;
  logic              rs_ge;
  logic              sat;
  logic signed [QuoW-1:0] quo_s;

  assign dv    = {dd_q, 2'b00};
  assign rs    = {rem_q, low_q[IterN-1]};
  assign rs_ge = rs >= {1'b0, dv};
  assign sat   = mag_q >= NumW'({dv, {IterN{1'b0}}});

  always_comb begin
    dv_state_d = dv_state_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    unique case (dv_state_q)
      DV_IDLE: begin
        if (start_i) dv_state_d = DV_ROUND;
      end
      DV_ROUND: dv_state_d = DV_CHECK;
      DV_CHECK: begin
        cnt_d = '0;
        if (sat) begin
          done_d     = 1'b1;
          dv_state_d = DV_IDLE;
        end else begin
          dv_state_d = DV_ITER;
        end
      end
      DV_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(IterN - 1)) begin
          done_d     = 1'b1;
          dv_state_d = DV_IDLE;
        end
      end
      default: dv_state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_state_q <= DV_IDLE;
      done_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      dv_state_q <= dv_state_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (dv_state_q)
      DV_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[NumW-1];
          mag_q <= num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
          // zero damping divides as one
          dd_q  <= (den_i == 16'd0) ? 16'd1 : den_i;
        end
      end
      DV_ROUND: mag_q <= mag_q + NumW'({dd_q, 1'b0});
      DV_CHECK: begin
        if (sat) begin
          quo_q <= {1'b1, {IterN{1'b0}}};
        end else begin
          quo_q <= '0;
          rem_q <= mag_q[DenW+IterN-1:IterN];
          low_q <= mag_q[IterN-1:0];
        end
      end
      DV_ITER: begin
        rem_q <= rs_ge ? DenW'(rs - {1'b0, dv}) : rs[DenW-1:0];
        low_q <= {low_q[IterN-2:0], 1'b0};
        quo_q <= {quo_q[IterN-1:0], rs_ge};
      end
      default: ;
    endcase
  end

  assign quo_s  = $signed({1'b0, quo_q});
  assign quo_o  = neg_q ? -quo_s : quo_s;
  assign stat_o = '{busy: (dv_state_q != DV_IDLE), done: done_q};

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> dv_state_q == DV_IDLE)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> dv_state_q == DV_IDLE && !$past(start_i))
    else $error("divider done without returning to idle");
`endif

endmodule

@@ design/admittance_velocity_controller.sv @@
// admittance velocity controller: one beat is worked at a time, and the input stalls until
// its result is taken; a quotient that saturates skips the divider's iteration steps
// the work per beat is set by the shared 17-step divider, run once per command, plus setup steps
// a result waits in the output register while the output stalls
// rst_ni clears state, stored velocities and the configuration to its defaults at once
module admittance_velocity_controller
  import avc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  avc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output avc_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned AccW = 24;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_MLIN = 7'b0000100,
    S_DLIN = 7'b0001000,
    S_MANG = 7'b0010000,
    S_DANG = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  avc_cfg_t               cfg;
  avc_in_t                in_q;
  logic signed [15:0]     prev_lin_q, prev_ang_q;
  logic signed [AccW-1:0] acc_lin_q, acc_ang_q;
  logic signed [VtW-1:0]  force98_q;
  logic signed [NumW-1:0] num_q;
  logic signed [15:0]     cmd_lin_q, cmd_ang_q;
  logic                   start_q, start_d;
  logic                   out_valid_q;
  avc_out_t               out_q;
  logic                   in_fire, out_free;
  logic signed [VtW-1:0]  vt20;
  logic signed [15:0]     vt_sat;
  avc_div_stat_t          div_stat;
  logic signed [QuoW-1:0] quo;
  logic [15:0]            div_den;
  logic signed [16:0]     diff_lin, diff_ang;
  logic        [15:0]     mul_a;
  logic signed [AccW-1:0] mul_b;
  logic signed [NumW-1:0] prod;
  logic signed [VtW-1:0]  num_base;
  logic signed [15:0]     ang_neg;

  function automatic logic signed [15:0] clamp_cmd(logic signed [QuoW-1:0] v,
                                                   logic signed [15:0] hi,
                                                   logic signed [15:0] lo);
    logic signed [QuoW-1:0] hi_x;
    logic signed [QuoW-1:0] lo_x;
    hi_x = QuoW'(hi);
    lo_x = QuoW'(lo);
    if (v >= hi_x) return hi;
    if (v <= lo_x) return lo;
    return v[15:0];
  endfunction

  avc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  avc_vtorque u_vtorque (
    .clk_i    (clk_i),
    .load_i   (state_q == S_PREP),
    .torque_i (in_q.torque_yaw),
    .err_i    (in_q.orient_error),
    .assist_i (in_q.assist_mode),
    .vt20_o   (vt20),
    .vt_sat_o (vt_sat)
  );

  assign div_den = (state_q == S_DANG) ? cfg.damp_ang : cfg.damp_lin;

  avc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (num_q),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // velocity differences, times 100
  assign diff_lin = $signed({in_q.meas_lin_vel[15], in_q.meas_lin_vel})
                  - $signed({prev_lin_q[15], prev_lin_q});
  assign diff_ang = $signed({in_q.meas_ang_vel[15], in_q.meas_ang_vel})
                  - $signed({prev_ang_q[15], prev_ang_q});

  // one multiplier serves both mass terms
  assign mul_a    = (state_q == S_MANG) ? cfg.mass_ang : cfg.mass_lin;
  assign mul_b    = (state_q == S_MANG) ? acc_ang_q : acc_lin_q;
  assign prod     = $signed({1'b0, mul_a}) * mul_b;
  assign num_base = (state_q == S_MANG) ? vt20 : force98_q;

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_PREP;
      S_PREP: state_d = S_MLIN;
      S_MLIN: begin
        state_d = S_DLIN;
        start_d = 1'b1;
      end
      S_DLIN: if (div_stat.done) state_d = S_MANG;
      S_MANG: begin
        state_d = S_DANG;
        start_d = 1'b1;
      end
      S_DANG: if (div_stat.done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      prev_lin_q  <= '0;
      prev_ang_q  <= '0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_PREP) begin
        prev_lin_q <= in_q.meas_lin_vel;
        prev_ang_q <= in_q.meas_ang_vel;
      end
    end
  end

  assign ang_neg = (cmd_ang_q == -16'sd32768) ? 16'sd32767 : -cmd_ang_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (state_q == S_PREP) begin
      acc_lin_q <= AccW'(diff_lin) * 24'sd100;
      acc_ang_q <= AccW'(diff_ang) * 24'sd100;
      force98_q <= in_q.force_fwd * $signed({1'b0, 16'(G98Q12)});
    end
    if (state_q == S_MLIN || state_q == S_MANG) begin
      num_q <= NumW'(num_base) - prod;
    end
    if (state_q == S_DLIN && div_stat.done) begin
      cmd_lin_q <= clamp_cmd(quo, cfg.lin_vel_max, cfg.lin_vel_min);
    end
    if (state_q == S_DANG && div_stat.done) begin
      cmd_ang_q <= clamp_cmd(quo, cfg.ang_vel_max, cfg.ang_vel_min);
    end
    if (state_q == S_DONE && out_free) begin
      out_q.lin_cmd     <= cmd_lin_q;
      out_q.ang_cmd     <= ang_neg;
      out_q.virt_torque <= vt_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the finishing step");

  a_ang_negation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.ang_cmd != -16'sd32768)
    else $error("angular command negation overflowed");
`endif

endmodule
